>>> rtl/fca_pkg.sv
// Shared types, codes and constants of the block-link table allocator.
`timescale 1ns / 1ps

package fca_pkg;

    localparam int NUM_BLOCKS_DFLT = 1024;

    localparam int IDX_W      = 11;
    localparam int LINK_W     = 10;
    localparam int TOTAL_W    = 11;
    localparam int FIRST_W    = 10;
    localparam int CNT_W      = 11;
    localparam int CFG_W      = 11;
    localparam int CFG_ADDR_W = 1;

    typedef logic [1:0]              t_cmd;
    typedef logic signed [IDX_W-1:0] t_idx;
    typedef logic [LINK_W-1:0]       t_links;
    typedef logic [1:0]              t_status;
    typedef logic [CNT_W-1:0]        t_cnt;
    typedef logic [TOTAL_W-1:0]      t_total;
    typedef logic [FIRST_W-1:0]      t_first;
    typedef logic [CFG_ADDR_W-1:0]   t_cfg_addr;
    typedef logic [CFG_W-1:0]        t_cfg_data;

    // Commands
    localparam t_cmd CMD_FORMAT = 2'd0;
    localparam t_cmd CMD_WALK   = 2'd1;
    localparam t_cmd CMD_APPEND = 2'd2;
    localparam t_cmd CMD_FREE   = 2'd3;

    // Result status codes
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NO_FREE = 2'd1;
    localparam t_status ST_BAD     = 2'd2;

    // Configuration register indexes
    localparam t_cfg_addr REG_TOTAL_BLOCKS = 1'd0;
    localparam t_cfg_addr REG_FIRST_DATA   = 1'd1;

    localparam t_total TOTAL_RST  = 11'd1024;
    localparam t_first FIRST_RST  = 10'd41;
    localparam t_cnt   CNT_MAX    = '1;
    localparam t_idx   BLOCK_NONE = '1;

endpackage

>>> rtl/fca_in_if.sv
// Command channel: valid/ready handshake carrying one allocator command.
`timescale 1ns / 1ps

interface fca_in_if;
    logic              valid;
    logic              ready;
    fca_pkg::t_cmd     command;
    fca_pkg::t_idx     block_index;
    fca_pkg::t_links   link_count;

    modport source (output valid, output command, output block_index, output link_count,
                    input ready);
    modport sink   (input valid, input command, input block_index, input link_count,
                    output ready);
endinterface

>>> rtl/fca_out_if.sv
// Result channel: valid/ready handshake carrying one allocator result.
`timescale 1ns / 1ps

interface fca_out_if;
    logic              valid;
    logic              ready;
    fca_pkg::t_status  status;
    fca_pkg::t_idx     block_out;
    fca_pkg::t_cnt     freed_count;
    fca_pkg::t_cnt     free_left;

    modport source (output valid, output status, output block_out, output freed_count,
                    output free_left, input ready);
    modport sink   (input valid, input status, input block_out, input freed_count,
                    input free_left, output ready);
endinterface

>>> rtl/fat_chain_allocator_top.sv
// Top level: block-link table allocator with a sequencer around one table memory.
`timescale 1ns / 1ps

//  channel   dir  handshake          payload
//  i_in      in   valid / ready      command, block_index, link_count
//  o_out     out  valid / ready      status, block_out, freed_count, free_left
//  i_cfg_*   in   write enable only  i_cfg_addr selects register, i_cfg_wdata
//
//  One transaction at a time; one table read and one write per cycle. A walk follows the
//  links, a free releases the chain entry by entry, a format reruns the clearing pass,
//  and an append checks a given previous block, scans for a free entry and then links it
//  or reports none. After reset a clearing pass marks every entry free; i_in.ready
//  stays low during it while config writes are still taken.
//  A result waits in the output register; the next result holds in the done state.

module fat_chain_allocator_top #(
    parameter int NUM_BLOCKS = fca_pkg::NUM_BLOCKS_DFLT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  fca_pkg::t_cfg_addr  i_cfg_addr,
    input  fca_pkg::t_cfg_data  i_cfg_wdata,
    fca_in_if.sink              i_in,
    fca_out_if.source           o_out
);
    import fca_pkg::*;

    localparam int AW = $clog2(NUM_BLOCKS);             // table address width
    localparam int EW = AW + 1;                         // entry: mark bit + index
    localparam int UW = (AW + 1 > TOTAL_W) ? AW + 1 : TOTAL_W;  // counts, limits

    localparam logic [EW-1:0] FREE_ENT = {1'b1, AW'(0)};
    localparam logic [EW-1:0] END_ENT  = {1'b1, AW'(1)};
    localparam logic [AW-1:0] CLR_LAST = AW'(NUM_BLOCKS - 1);
    localparam logic [UW-1:0] NUM_U    = UW'(NUM_BLOCKS);

    // Free count after reset, from the reset values of the registers
    localparam int RST_USED = (NUM_BLOCKS < int'(TOTAL_RST)) ? NUM_BLOCKS : int'(TOTAL_RST);
    localparam int RST_DIFF = (RST_USED > int'(FIRST_RST)) ? RST_USED - int'(FIRST_RST) : 0;
    localparam int RST_FREE = (RST_DIFF > int'(CNT_MAX)) ? int'(CNT_MAX) : RST_DIFF;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_WALK, S_APREV, S_SCAN, S_ALINK, S_FREE, S_DONE
    } t_state;

    // Sequencer and datapath registers
    t_state          r_state,      n_state;
    logic            r_fmt,        n_fmt;
    logic [AW-1:0]   r_clr,        n_clr;
    logic [AW-1:0]   r_cur,        n_cur;
    logic [AW-1:0]   r_prev,       n_prev;
    logic            r_has_prev,   n_has_prev;
    t_links          r_links,      n_links;
    logic            r_first,      n_first;
    logic [UW-1:0]   r_scan,       n_scan;
    logic [AW-1:0]   r_chk,        n_chk;
    logic            r_chk_vld,    n_chk_vld;
    logic            r_byp,        n_byp;
    logic [EW-1:0]   r_byp_data,   n_byp_data;
    t_total          r_total,      n_total;
    t_first          r_fdb,        n_fdb;
    t_cnt            r_free_total, n_free_total;
    t_status         r_res_status, n_res_status;
    t_idx            r_res_block,  n_res_block;
    t_cnt            r_res_freed,  n_res_freed;
    logic            r_out_valid,  n_out_valid;
    t_status         r_out_status, n_out_status;
    t_idx            r_out_block,  n_out_block;
    t_cnt            r_out_freed,  n_out_freed;
    t_cnt            r_out_free,   n_out_free;

    // Table memory
    logic [EW-1:0]   r_mem [NUM_BLOCKS];
    logic [EW-1:0]   r_rd_data;
    logic [AW-1:0]   rd_addr;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [EW-1:0]   mem_wdata;

    // Decode helpers
    logic [UW-1:0]   total_u;
    logic [UW-1:0]   used;
    logic [UW-1:0]   fdb_u;
    logic [UW-1:0]   fmt_diff;
    t_cnt            fmt_free;
    logic            idx_none;
    logic [UW-1:0]   in_idx_u;
    logic [AW-1:0]   in_addr;
    logic            in_valid_idx;
    logic [EW-1:0]   rd_ent;
    logic [AW-1:0]   rd_idx;
    logic            rd_free;
    logic            rd_end;
    logic            rd_link_ok;
    logic            out_free_slot;

    // Entries in use: the register value, limited to the table size
    assign total_u  = UW'(r_total);
    assign used     = (total_u > NUM_U) ? NUM_U : total_u;
    assign fdb_u    = UW'(r_fdb);
    assign fmt_diff = (used > fdb_u) ? used - fdb_u : '0;
    assign fmt_free = (fmt_diff > UW'(CNT_MAX)) ? CNT_MAX : fmt_diff[CNT_W-1:0];

    assign idx_none     = (i_in.block_index == BLOCK_NONE);
    assign in_idx_u     = UW'(i_in.block_index[IDX_W-2:0]);
    assign in_valid_idx = !i_in.block_index[IDX_W-1] && (in_idx_u < used);
    assign in_addr      = in_idx_u[AW-1:0];

    // Read data, with the entry written in the same cycle forwarded
    assign rd_ent     = r_byp ? r_byp_data : r_rd_data;
    assign rd_idx     = rd_ent[AW-1:0];
    assign rd_free    = (rd_ent == FREE_ENT);
    assign rd_end     = (rd_ent == END_ENT);
    assign rd_link_ok = !rd_ent[AW] && (UW'(rd_idx) < used);

    assign out_free_slot = !r_out_valid || o_out.ready;

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.block_out   = r_out_block;
    assign o_out.freed_count = r_out_freed;
    assign o_out.free_left   = r_out_free;

    always_comb begin
        n_state      = r_state;
        n_fmt        = r_fmt;
        n_clr        = r_clr;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_has_prev   = r_has_prev;
        n_links      = r_links;
        n_first      = r_first;
        n_scan       = r_scan;
        n_chk        = r_chk;
        n_chk_vld    = r_chk_vld;
        n_total      = r_total;
        n_fdb        = r_fdb;
        n_free_total = r_free_total;
        n_res_status = r_res_status;
        n_res_block  = r_res_block;
        n_res_freed  = r_res_freed;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_out_status = r_out_status;
        n_out_block  = r_out_block;
        n_out_freed  = r_out_freed;
        n_out_free   = r_out_free;
        rd_addr      = r_cur;
        mem_we       = 1'b0;
        mem_waddr    = r_cur;
        mem_wdata    = FREE_ENT;

        // Configuration writes land whenever they come
        if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_TOTAL_BLOCKS: n_total = i_cfg_wdata[TOTAL_W-1:0];
                REG_FIRST_DATA:   n_fdb   = i_cfg_wdata[FIRST_W-1:0];
                default:          n_total = r_total;
            endcase
        end

        case (r_state)
            S_CLEAR: begin
                // Sweep every entry to free
                mem_we    = 1'b1;
                mem_waddr = r_clr;
                n_clr     = r_clr + AW'(1);
                if (r_clr == CLR_LAST) begin
                    n_clr   = '0;
                    n_state = r_fmt ? S_DONE : S_IDLE;
                end
            end

            S_IDLE: begin
                rd_addr = in_addr;
                if (i_in.valid) begin
                    n_res_status = ST_OK;
                    n_res_block  = BLOCK_NONE;
                    n_res_freed  = '0;
                    n_cur        = in_addr;
                    n_prev       = in_addr;
                    n_has_prev   = !idx_none;
                    n_links      = i_in.link_count;
                    n_first      = 1'b1;
                    n_scan       = fdb_u;
                    n_chk_vld    = 1'b0;
                    n_fmt        = 1'b0;
                    case (i_in.command)
                        CMD_FORMAT: begin
                            n_fmt        = 1'b1;
                            n_clr        = '0;
                            n_free_total = fmt_free;
                            n_state      = S_CLEAR;
                        end
                        CMD_WALK: begin
                            if (in_valid_idx) begin
                                n_state = S_WALK;
                            end else begin
                                n_res_status = ST_BAD;
                                n_state      = S_DONE;
                            end
                        end
                        CMD_APPEND: begin
                            if (idx_none) begin
                                n_state = S_SCAN;
                            end else if (in_valid_idx) begin
                                n_state = S_APREV;
                            end else begin
                                n_res_status = ST_BAD;
                                n_state      = S_DONE;
                            end
                        end
                        CMD_FREE: begin
                            if (in_valid_idx) begin
                                n_state = S_FREE;
                            end else begin
                                n_res_status = ST_BAD;
                                n_state      = S_DONE;
                            end
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end

            S_WALK: begin
                // rd_ent holds the entry of r_cur
                rd_addr = rd_idx;
                if (r_first && rd_free) begin
                    n_res_status = ST_BAD;
                    n_state      = S_DONE;
                end else if (r_links == '0) begin
                    n_res_block = t_idx'(r_cur);
                    n_state     = S_DONE;
                end else if (!rd_link_ok) begin
                    n_res_status = ST_BAD;
                    n_state      = S_DONE;
                end else begin
                    n_cur   = rd_idx;
                    n_links = r_links - LINK_W'(1);
                    n_first = 1'b0;
                end
            end

            S_APREV: begin
                // Previous block must be a chain end
                if (!rd_end) begin
                    n_res_status = ST_BAD;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_SCAN;
                end
            end

            S_SCAN: begin
                // One read issued per cycle; r_chk is the entry whose data is back
                rd_addr = r_scan[AW-1:0];
                if (r_chk_vld && rd_free) begin
                    mem_we       = 1'b1;
                    mem_waddr    = r_chk;
                    mem_wdata    = END_ENT;
                    n_cur        = r_chk;
                    n_res_block  = t_idx'(r_chk);
                    n_free_total = (r_free_total != '0) ? r_free_total - CNT_W'(1)
                                                        : r_free_total;
                    n_state      = r_has_prev ? S_ALINK : S_DONE;
                end else if (!r_chk_vld && (r_scan >= used)) begin
                    n_res_status = ST_NO_FREE;
                    n_state      = S_DONE;
                end else begin
                    n_chk     = r_scan[AW-1:0];
                    n_chk_vld = (r_scan < used);
                    if (r_scan < used) begin
                        n_scan = r_scan + UW'(1);
                    end
                end
            end

            S_ALINK: begin
                // Link the new block after the old chain end
                mem_we    = 1'b1;
                mem_waddr = r_prev;
                mem_wdata = {1'b0, r_cur};
                n_state   = S_DONE;
            end

            S_FREE: begin
                // rd_ent holds the entry of r_cur; a free mark ends the chain badly
                rd_addr = rd_idx;
                if (rd_free) begin
                    n_res_status = ST_BAD;
                    n_state      = S_DONE;
                end else begin
                    mem_we       = 1'b1;
                    mem_waddr    = r_cur;
                    mem_wdata    = FREE_ENT;
                    n_first      = 1'b0;
                    n_res_freed  = (r_res_freed != CNT_MAX) ? r_res_freed + CNT_W'(1)
                                                            : r_res_freed;
                    n_free_total = (r_free_total != CNT_MAX) ? r_free_total + CNT_W'(1)
                                                             : r_free_total;
                    if (rd_end) begin
                        n_state = S_DONE;
                    end else if (!rd_link_ok) begin
                        n_res_status = ST_BAD;
                        n_state      = S_DONE;
                    end else begin
                        n_cur = rd_idx;
                    end
                end
            end

            S_DONE: begin
                // Hold the result until the output register is free
                if (out_free_slot) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_block  = r_res_block;
                    n_out_freed  = r_res_freed;
                    n_out_free   = n_free_total;
                    n_state      = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Forward a same-cycle write to the following read
    assign n_byp      = mem_we && (mem_waddr == rd_addr);
    assign n_byp_data = mem_wdata;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_fmt        <= 1'b0;
            r_clr        <= '0;
            r_chk_vld    <= 1'b0;
            r_byp        <= 1'b0;
            r_total      <= TOTAL_RST;
            r_fdb        <= FIRST_RST;
            r_free_total <= CNT_W'(RST_FREE);
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_fmt        <= n_fmt;
            r_clr        <= n_clr;
            r_chk_vld    <= n_chk_vld;
            r_byp        <= n_byp;
            r_total      <= n_total;
            r_fdb        <= n_fdb;
            r_free_total <= n_free_total;
            r_out_valid  <= n_out_valid;
        end
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_has_prev   <= n_has_prev;
        r_links      <= n_links;
        r_first      <= n_first;
        r_scan       <= n_scan;
        r_chk        <= n_chk;
        r_byp_data   <= n_byp_data;
        r_res_status <= n_res_status;
        r_res_block  <= n_res_block;
        r_res_freed  <= n_res_freed;
        r_out_status <= n_out_status;
        r_out_block  <= n_out_block;
        r_out_freed  <= n_out_freed;
        r_out_free   <= n_out_free;
    end

    // A new result enters the output register only from the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == S_DONE)
        else $error("result loaded outside the done state");

    // A scanned entry under test always lies inside the table in use
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && r_chk_vld |-> UW'(r_chk) < used)
        else $error("free search checked an entry past the table end");

    // Linking after a previous block only happens when one was given
    a_link_has_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ALINK) |-> r_has_prev)
        else $error("append linked without a previous block");

endmodule
